>>> hdl/plir_pkg.sv
// plir_pkg: shared types and codes for the positional list block
// request codes, status codes and the per-cell shift control struct
// no dependencies
package plir_pkg;

	typedef enum logic [2:0] {
		REQ_INS_FRONT = 3'd0,
		REQ_INS_END   = 3'd1,
		REQ_INS_POS   = 3'd2,
		REQ_REM_FRONT = 3'd3,
		REQ_REM_END   = 3'd4,
		REQ_REM_POS   = 3'd5
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef struct packed {
		logic ins;
		logic rem;
	} shift_t;

	localparam int GRP = 32;
	localparam int REQ_W = 3;
	localparam int POS_W = 11;
	localparam int VAL_W = 16;
	localparam int CNT_W = 11;

endpackage

>>> hdl/positional_list_insert_remove_top.sv
// positional_list_insert_remove_top: packed list held in a chain of shifting cells
// depends on plir_pkg, plir_cell, plir_group_or
// result: the cells shift at acceptance, and the removed entry is gathered through a registered
// group or-tree (group registers, then the output register) before out_valid rises
// handshake: no new item is accepted until the result is taken; the gather tree
// and single output register set this. reset clears the count and handshake state only
module positional_list_insert_remove_top #(
	parameter int DEPTH       = 1024,
	parameter int ENTRY_WIDTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [2:0]                 req_type,
	input  logic [10:0]                position,
	input  logic [15:0]                entry_value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output plir_pkg::status_t          status,
	output logic [15:0]                removed_value,
	output logic [10:0]                entry_count
);
	import plir_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = ENTRY_WIDTH;
	localparam int NG = (DEPTH + GRP - 1) / GRP;
	localparam int PW = (CW > POS_W) ? CW : POS_W;
	localparam int XV = (EW > VAL_W) ? EW : VAL_W;
	localparam int XC = (CW > CNT_W) ? CW : CNT_W;

	logic [CW-1:0]  count_q;
	logic           gather_q;
	logic           out_valid_q;
	status_t        status_q;
	logic [CW-1:0]  count_out_q;
	logic [EW-1:0]  removed_q;

	logic           accept;
	shift_t         ctrl;
	logic [CW-1:0]  idx;
	status_t        st;
	logic [CW-1:0]  count_nxt;
	logic           full;
	logic           empty;
	logic [PW-1:0]  pos_w;
	logic [PW-1:0]  cnt_w;
	logic [XV-1:0]  val_ext;
	logic [EW-1:0]  new_val;
	logic [XV-1:0]  rem_ext;
	logic [XC-1:0]  cnt_ext;

	logic [DEPTH-1:0][EW-1:0]    cell_q;
	logic [NG*GRP-1:0][EW-1:0]   picks;
	logic [NG-1:0][EW-1:0]       grp_q;
	logic [EW-1:0]               gathered;

	assign in_ready = !gather_q && !out_valid_q;
	assign accept   = in_valid && in_ready;
	assign full     = (count_q >= CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pos_w    = PW'(position);
	assign cnt_w    = PW'(count_q);
	assign val_ext  = XV'(entry_value);
	assign new_val  = val_ext[EW-1:0];

	always_comb begin
		ctrl      = '0;
		idx       = '0;
		st        = ST_OK;
		count_nxt = count_q;
		unique case (req_type)
			REQ_INS_FRONT: begin
				if (full)
					st = ST_FULL;
				else
					ctrl.ins = 1'b1;
			end
			REQ_INS_END: begin
				idx = count_q;
				if (full)
					st = ST_FULL;
				else
					ctrl.ins = 1'b1;
			end
			REQ_INS_POS: begin
				idx = CW'(position);
				if (pos_w > cnt_w)
					st = ST_RANGE;
				else if (full)
					st = ST_FULL;
				else
					ctrl.ins = 1'b1;
			end
			REQ_REM_FRONT: begin
				if (empty)
					st = ST_EMPTY;
				else
					ctrl.rem = 1'b1;
			end
			REQ_REM_END: begin
				idx = count_q - CW'(1);
				if (empty)
					st = ST_EMPTY;
				else
					ctrl.rem = 1'b1;
			end
			REQ_REM_POS: begin
				idx = CW'(position);
				if (empty)
					st = ST_EMPTY;
				else if (pos_w >= cnt_w)
					st = ST_RANGE;
				else
					ctrl.rem = 1'b1;
			end
			default: begin
				st = ST_OK;
			end
		endcase
		if (ctrl.ins)
			count_nxt = count_q + CW'(1);
		else if (ctrl.rem)
			count_nxt = count_q - CW'(1);
		if (!accept)
			ctrl = '0;
	end

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic [EW-1:0] lower;
			logic [EW-1:0] upper;
			if (gi == 0) begin : g_first
				assign lower = '0;
			end else begin : g_mid_lo
				assign lower = cell_q[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_last
				assign upper = '0;
			end else begin : g_mid_hi
				assign upper = cell_q[gi+1];
			end
			plir_cell #(
				.IDX (gi),
				.CW  (CW),
				.EW  (EW)
			) u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.idx       (idx),
				.new_val   (new_val),
				.lower_val (lower),
				.upper_val (upper),
				.val_q     (cell_q[gi]),
				.pick      (picks[gi])
			);
		end
		for (gi = DEPTH; gi < NG * GRP; gi++) begin : g_pad
			assign picks[gi] = '0;
		end
		for (gi = 0; gi < NG; gi++) begin : g_grp
			plir_group_or #(
				.N  (GRP),
				.EW (EW)
			) u_grp (
				.clk   (clk),
				.picks (picks[gi*GRP +: GRP]),
				.grp_q (grp_q[gi])
			);
		end
	endgenerate

	always_comb begin
		gathered = '0;
		for (int g = 0; g < NG; g++)
			gathered = gathered | grp_q[g];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			gather_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q  <= count_nxt;
				gather_q <= 1'b1;
			end else if (gather_q) begin
				gather_q    <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= st;
			count_out_q <= count_nxt;
		end
		if (gather_q)
			removed_q <= gathered;
	end

	assign rem_ext       = XV'(removed_q);
	assign cnt_ext       = XC'(count_out_q);
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign removed_value = rem_ext[VAL_W-1:0];
	assign entry_count   = cnt_ext[CNT_W-1:0];

endmodule

>>> hdl/plir_cell.sv
// plir_cell: one list slot; loads from its lower or upper neighbor or the new item
// depends on plir_pkg
module plir_cell #(
	parameter int IDX = 0,
	parameter int CW  = 11,
	parameter int EW  = 16
) (
	input  logic               clk,
	input  plir_pkg::shift_t   ctrl,
	input  logic [CW-1:0]      idx,
	input  logic [EW-1:0]      new_val,
	input  logic [EW-1:0]      lower_val,
	input  logic [EW-1:0]      upper_val,
	output logic [EW-1:0]      val_q,
	output logic [EW-1:0]      pick
);
	import plir_pkg::*;

	localparam logic [CW-1:0] MY = CW'(IDX);

	logic hit;
	logic above;

	assign hit   = (MY == idx);
	assign above = (MY > idx);
	assign pick  = (ctrl.rem && hit) ? val_q : '0;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (above)
				val_q <= lower_val;
			else if (hit)
				val_q <= new_val;
		end else if (ctrl.rem) begin
			if (above || hit)
				val_q <= upper_val;
		end
	end

endmodule

>>> hdl/plir_group_or.sv
// plir_group_or: registered or-reduction of the removal picks of one group of cells
// depends on plir_pkg
module plir_group_or #(
	parameter int N  = 32,
	parameter int EW = 16
) (
	input  logic                 clk,
	input  logic [N-1:0][EW-1:0] picks,
	output logic [EW-1:0]        grp_q
);
	import plir_pkg::*;

	logic [EW-1:0] acc;

	always_comb begin
		acc = '0;
		for (int i = 0; i < N; i++)
			acc = acc | picks[i];
	end

	always_ff @(posedge clk) begin
		grp_q <= acc;
	end

endmodule
